// ===== design/imfp_pkg.sv =====
// shared types, codes and command tables for the irc message field parser
`default_nettype none
package imfp_pkg;

  typedef enum logic [2:0] {
    RK_SERVER  = 3'd0,
    RK_NICK    = 3'd1,
    RK_USER    = 3'd2,
    RK_HOST    = 3'd3,
    RK_COMMAND = 3'd4,
    RK_PARAM   = 3'd5,
    RK_RAW     = 3'd6,
    RK_END     = 3'd7
  } rec_kind_e;

  localparam logic [4:0] CODE_UNKNOWN = 5'd0;
  localparam logic [4:0] CODE_NUMERIC = 5'd1;
  localparam logic [4:0] CODE_MODE    = 5'd9;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int NUM_WORDS = 15;

  // words right-justified as string literals, codes are index plus two
  localparam logic [55:0] WORD_TXT [NUM_WORDS] = '{
    56'("JOIN"), 56'("PART"), 56'("PING"), 56'("PONG"), 56'("NICK"),
    56'("KICK"), 56'("QUIT"), 56'("MODE"), 56'("KILL"), 56'("AWAY"),
    56'("TOPIC"), 56'("SQUIT"), 56'("ERROR"), 56'("NOTICE"), 56'("PRIVMSG")
  };
  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd6, 4'd7
  };

  typedef struct packed {
    rec_kind_e   kind;
    logic [8:0]  off;
    logic [9:0]  len;
    logic [4:0]  code;
    logic [9:0]  num;
    logic [3:0]  idx;
    logic        trl;
    logic        err;
    logic        add;
    logic [7:0]  mch;
    logic        crlf;
  } rec_t;

  typedef struct packed {
    logic  v0;
    logic  v1;
    rec_t  r0;
    rec_t  r1;
  } rec_pair_t;

  localparam rec_t REC_ZERO = '{kind: RK_SERVER, default: '0};

  function automatic logic [3:0] max_param(input logic [4:0] code);
    logic [3:0] m;
    unique case (code)
      5'd2, 5'd3, 5'd9, 5'd10, 5'd12, 5'd13, 5'd15, 5'd16: m = 4'd2;
      5'd6, 5'd8, 5'd11, 5'd14:                            m = 4'd1;
      5'd7:                                                m = 4'd3;
      default:                                             m = 4'd0;
    endcase
    return m;
  endfunction

  function automatic logic is_numeric(input logic [55:0] cb, input logic [3:0] cl);
    logic ok;
    ok = (cl == 4'd3);
    for (int i = 0; i < 3; i++) begin
      if (cb[8*i +: 8] < 8'h30 || cb[8*i +: 8] > 8'h39) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [4:0] cmd_code(input logic [55:0] cb, input logic [3:0] cl);
    logic [4:0]  code;
    logic [55:0] rev;
    code = CODE_UNKNOWN;
    if (is_numeric(cb, cl)) begin
      code = CODE_NUMERIC;
    end else begin
      for (int w = NUM_WORDS - 1; w >= 0; w--) begin
        rev = '0;
        for (int i = 0; i < 7; i++) begin
          if (i < int'(WORD_LEN[w])) rev[8*i +: 8] = WORD_TXT[w][8*(int'(WORD_LEN[w])-1-i) +: 8];
        end
        if (cl == WORD_LEN[w] && cb == rev) code = 5'(w + 2);
      end
    end
    return code;
  endfunction

  function automatic logic [9:0] cmd_num(input logic [55:0] cb, input logic [3:0] cl);
    logic [9:0] n;
    n = '0;
    if (is_numeric(cb, cl)) begin
      n = 10'(cb[3:0]) * 10'd100 + 10'(cb[11:8]) * 10'd10 + 10'(cb[19:16]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== design/imfp_step.sv =====
// parse state and per-item record generation
`default_nettype none
module imfp_step
  import imfp_pkg::*;
#(
  parameter int BUFFER_BYTES = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       go_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       end_i,
  output logic            consume_o,
  output rec_pair_t       recs_o
);

  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam logic [PW:0]   BB_W  = (PW+1)'(BUFFER_BYTES);
  localparam logic [PW-1:0] BB_M1 = PW'(BUFFER_BYTES - 1);

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_PREFIX  = 5'b00010,
    PH_COMMAND = 5'b00100,
    PH_PARAMS  = 5'b01000,
    PH_RAW     = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    PK_UND = 2'd0, PK_SERVER = 2'd1, PK_USER = 2'd2, PK_NONE = 2'd3
  } pkind_e;

  phase_e        phase_q, phase_d;
  pkind_e        pkind_q, pkind_d;
  logic          lpd_q, lpd_d, cr_q, cr_d, trl_q, trl_d;
  logic [PW-1:0] ts_q, ts_d, mp_q, mp_d, nx;
  logic [55:0]   cb_q, cb_d;
  logic [3:0]    cl_q, cl_d, pc_q, pc_d, pc_n;
  logic [4:0]    ck_d, ck_full_q, code;
  logic [15:0]   ph_q, ph_d;
  logic [9:0]    num;
  logic [PW-1:0] plen;
  logic          tok_take, tok_fin, is_lf;
  logic [7:0]    tb;
  rec_t          cmd_rec, par_rec, end_rec;

  function automatic logic [PW-1:0] span(input logic [PW-1:0] f, input logic [PW-1:0] t);
    return (t > f) ? PW'(t - f) : '0;
  endfunction

  function automatic rec_t mk(input rec_kind_e k, input logic [PW-1:0] o,
                              input logic [PW-1:0] l);
    rec_t r;
    logic [31:0] ow, lw;
    r = REC_ZERO;
    ow = 32'((o > BB_M1) ? BB_M1 : o);
    lw = 32'(l);
    r.kind = k;
    r.off  = ow[8:0];
    r.len  = lw[9:0];
    return r;
  endfunction

  assign nx   = (mp_q >= BB_W[PW-1:0]) ? BB_W[PW-1:0] : PW'({1'b0, mp_q} + 1'b1);
  assign code = cmd_code(cb_q, cl_q);
  assign num  = cmd_num(cb_q, cl_q);
  assign plen = span(ts_q, mp_q);
  assign pc_n = (pc_q < 4'd15) ? pc_q + 4'd1 : 4'd15;
  assign is_lf = !end_i && byte_i == CH_LF;
  assign tb   = cr_q ? CH_CR : byte_i;

  // a held cr ahead of anything but lf is taken first, while the item is held back
  assign tok_take  = go_i && (cr_q ? !is_lf : (!end_i && byte_i != CH_CR));
  assign tok_fin   = go_i && (cr_q ? is_lf : end_i);
  assign consume_o = go_i && !(cr_q && !is_lf);

  always_comb begin
    cmd_rec = mk(RK_COMMAND, ts_q, plen);
    cmd_rec.code = code;
    cmd_rec.num  = num;
    par_rec = mk(RK_PARAM, ts_q, plen);
    par_rec.idx = pc_n;
    par_rec.trl = trl_q;
    par_rec.err = pc_n > max_param(ck_full_q);
    if (ck_full_q == CODE_MODE && pc_n == 4'd2 && !par_rec.err) begin
      if (plen < PW'(2) || (ph_q[7:0] != CH_PLUS && ph_q[7:0] != CH_MINUS)) begin
        par_rec.err = 1'b1;
      end else begin
        par_rec.add = ph_q[7:0] == CH_PLUS;
        par_rec.mch = ph_q[15:8];
      end
    end
    end_rec = mk(RK_END, '0, mp_q);
    end_rec.crlf = cr_q;
  end

  always_comb begin
    phase_d = phase_q; pkind_d = pkind_q; lpd_d = lpd_q; ts_d = ts_q; mp_d = mp_q;
    cr_d = cr_q; cb_d = cb_q; cl_d = cl_q; ck_d = ck_full_q; pc_d = pc_q;
    trl_d = trl_q; ph_d = ph_q;
    recs_o = '{v0: 1'b0, v1: 1'b0, r0: REC_ZERO, r1: REC_ZERO};

    if (go_i && !cr_q && !end_i && byte_i == CH_CR) cr_d = 1'b1;
    if (go_i && cr_q) cr_d = 1'b0;

    if (tok_take) begin
      mp_d = nx;
      unique case (phase_q)
        PH_START: begin
          if (tb == CH_COLON) begin
            phase_d = PH_PREFIX;
            ts_d = nx;
          end else begin
            pkind_d = PK_NONE;
            phase_d = PH_COMMAND;
            ts_d = mp_q;
            cb_d[8*cl_q[2:0] +: 8] = tb;
            cl_d = cl_q + 4'd1;
          end
        end
        PH_PREFIX: begin
          if (tb == CH_SPACE || tb == CH_AT || tb == CH_BANG) begin
            recs_o.v0 = 1'b1;
            if (pkind_q == PK_UND) begin
              recs_o.r0 = mk((tb == CH_SPACE) ? RK_SERVER : RK_NICK, ts_q, plen);
              pkind_d = (tb == CH_SPACE) ? PK_SERVER : PK_USER;
            end else begin
              recs_o.r0 = mk(lpd_q ? RK_HOST : RK_USER, ts_q, plen);
            end
            lpd_d = tb == CH_AT;
            ts_d = nx;
            if (tb == CH_SPACE) phase_d = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          if (tb == CH_SPACE) begin
            recs_o.v0 = 1'b1;
            recs_o.r0 = cmd_rec;
            ck_d = code;
            phase_d = (max_param(code) != 4'd0) ? PH_PARAMS : PH_RAW;
            ts_d = nx;
          end else begin
            if (cl_q < 4'd7) cb_d[8*cl_q[2:0] +: 8] = tb;
            if (cl_q < 4'd8) cl_d = cl_q + 4'd1;
          end
        end
        PH_PARAMS: begin
          if (!trl_q && tb == CH_COLON && mp_q == ts_q) begin
            trl_d = 1'b1;
            ts_d = nx;
          end else if (!trl_q && tb == CH_SPACE) begin
            recs_o.v0 = 1'b1;
            recs_o.r0 = par_rec;
            pc_d = pc_n;
            ph_d = '0;
            ts_d = nx;
          end else if (mp_q >= ts_q && plen == '0) begin
            ph_d[7:0] = tb;
          end else if (plen == PW'(1)) begin
            ph_d[15:8] = tb;
          end
        end
        PH_RAW: ;
        default: ;
      endcase
    end

    if (tok_fin) begin
      if (phase_q != PH_START || cr_q) begin
        recs_o.v0 = 1'b1;
        recs_o.r0 = end_rec;
        priority case (1'b1)
          phase_q == PH_START: begin
            recs_o.r0 = mk(RK_COMMAND, mp_q, '0);
            recs_o.r0.code = code;
            recs_o.r0.num  = num;
          end
          phase_q == PH_COMMAND: recs_o.r0 = cmd_rec;
          phase_q == PH_PARAMS:  recs_o.r0 = par_rec;
          phase_q == PH_RAW:     recs_o.r0 = mk(RK_RAW, ts_q, plen);
          default:               recs_o.v0 = 1'b1;
        endcase
        if (phase_q != PH_PREFIX) begin
          recs_o.v1 = 1'b1;
          recs_o.r1 = end_rec;
        end
      end
      phase_d = PH_START; pkind_d = PK_UND; lpd_d = 1'b0; ts_d = '0; mp_d = '0;
      cr_d = 1'b0; cb_d = '0; cl_d = '0; ck_d = CODE_UNKNOWN; pc_d = '0;
      trl_d = 1'b0; ph_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START; pkind_q <= PK_UND; lpd_q <= 1'b0; ts_q <= '0; mp_q <= '0;
      cr_q <= 1'b0; cb_q <= '0; cl_q <= '0; ck_full_q <= CODE_UNKNOWN; pc_q <= '0;
      trl_q <= 1'b0; ph_q <= '0;
    end else begin
      phase_q <= phase_d; pkind_q <= pkind_d; lpd_q <= lpd_d; ts_q <= ts_d; mp_q <= mp_d;
      cr_q <= cr_d; cb_q <= cb_d; cl_q <= cl_d; ck_full_q <= ck_d; pc_q <= pc_d;
      trl_q <= trl_d; ph_q <= ph_d;
    end
  end

  // the second record only follows a first one
  assert property (@(posedge clk_i) disable iff (!rst_ni) recs_o.v1 |-> recs_o.v0)
    else $error("second record without first");
  // message position never passes the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni) mp_q <= BB_W[PW-1:0])
    else $error("position past buffer size");
  // a finish always clears the held cr
  assert property (@(posedge clk_i) disable iff (!rst_ni) tok_fin |=> !cr_q)
    else $error("cr held across message end");

endmodule
`default_nettype wire

// ===== design/imfp_fifo.sv =====
// four-entry record queue, two writes and one read per cycle
`default_nettype none
module imfp_fifo
  import imfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  rec_pair_t push_i,
  input  wire logic pop_i,
  output logic      room_o,
  output logic      valid_o,
  output rec_t      head_o
);

  rec_t       mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] npush;
  logic       pop;

  assign pop     = pop_i && cnt_q != 3'd0;
  assign npush   = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign cnt_d   = cnt_q + 3'(npush) - 3'(pop);
  assign room_o  = cnt_q <= 3'd2;
  assign valid_o = cnt_q != 3'd0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_q] <= push_i.r0;
    if (push_i.v1) mem_q[wr_q + 2'd1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + 2'(pop);
      wr_q  <= wr_q + npush;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i.v0 |-> room_o)
    else $error("push without room");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !pop_i) |=> valid_o)
    else $error("record dropped while stalled");

endmodule
`default_nettype wire

// ===== design/irc_message_field_parser.sv =====
// top level of the irc message field parser
//
// channel  dir  tdata                tuser
// s_axis   in   rx_byte              buffer_end
// m_axis   out  packed record below  record_kind
//
// one item per cycle is taken while the record queue holds two or fewer
// records; a cr followed by anything but lf holds the item after it back, as
// the held cr is parsed before the waiting item. each item makes up to two
// records, which leave one per cycle while m_axis_tready is high through a
// four-entry queue. reset returns the parser to the start of a message, queue empty.
`default_nettype none
module irc_message_field_parser
  import imfp_pkg::*;
#(
  parameter int BUFFER_BYTES = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  wire logic [0:0]  s_axis_tuser,   // buffer_end[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // field_offset, field_length, command_code,
                                           // numeric_value, param_index, is_trailing,
                                           // param_error, mode_add, mode_char,
                                           // ended_by_crlf, zero pad
  output logic [2:0]       m_axis_tuser    // record_kind
);

  logic       in_vld_q, in_end_q, go, consume, room;
  logic [7:0] in_byte_q;
  rec_pair_t  recs;
  rec_t       head;

  assign go            = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tuser[0];
    end
  end

  imfp_step #(.BUFFER_BYTES(BUFFER_BYTES)) u_step (
    .clk_i, .rst_ni,
    .go_i      (go),
    .byte_i    (in_byte_q),
    .end_i     (in_end_q),
    .consume_o (consume),
    .recs_o    (recs)
  );

  imfp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (recs),
    .pop_i   (m_axis_tready),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .head_o  (head)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tdata = {6'd0, head.crlf, head.mch, head.add, head.err, head.trl,
                         head.idx, head.num, head.code, head.len, head.off};

endmodule
`default_nettype wire

// ===== sim/imfp_checker.sv =====
// checker for the irc message field parser: predicts records and compares them
module imfp_checker
  import imfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o,
  output int          records_seen_o
);

  localparam int BUF_BYTES = 512;

  typedef enum int {P_START, P_PREFIX, P_COMMAND, P_PARAMS, P_RAW} phase_e;
  typedef enum int {PF_UND, PF_SERVER, PF_USER, PF_NONE} pfx_e;

  string cmd_words [15] = '{"JOIN", "PART", "PING", "PONG", "NICK", "KICK", "QUIT",
    "MODE", "KILL", "AWAY", "TOPIC", "SQUIT", "ERROR", "NOTICE", "PRIVMSG"};

  rec_t        record_q [$];
  phase_e      phase;
  pfx_e        pfx;
  bit          delim_at;
  int          tok_start;
  int          pos;
  bit          cr_held;
  logic [55:0] cmd_bytes;
  int          cmd_len;
  int          cmd_kind;
  int          pcount;
  bit          trailing;
  logic [15:0] head;

  function automatic int param_limit(int code);
    case (code)
      2, 3, 9, 10, 12, 13, 15, 16: return 2;
      6, 8, 11, 14:                return 1;
      7:                           return 3;
      default:                     return 0;
    endcase
  endfunction

  function automatic int span(int from, int to);
    return (to > from) ? to - from : 0;
  endfunction

  task automatic clear_message();
    phase = P_START; pfx = PF_UND; delim_at = 0; tok_start = 0; pos = 0;
    cr_held = 0; cmd_bytes = '0; cmd_len = 0; cmd_kind = 0; pcount = 0;
    trailing = 0; head = '0;
  endtask

  task automatic emit(rec_kind_e kind, int off, int len, int code = 0, int num = 0,
                      int idx = 0, bit trl = 0, bit err = 0, bit add = 0,
                      logic [7:0] mch = '0, bit crlf = 0);
    rec_t r;
    r.kind = kind;
    r.off  = 9'((off > BUF_BYTES - 1) ? BUF_BYTES - 1 : off);
    r.len  = 10'((len > BUF_BYTES) ? BUF_BYTES : len);
    r.code = 5'(code); r.num = 10'(num); r.idx = 4'(idx);
    r.trl = trl; r.err = err; r.add = add; r.mch = mch; r.crlf = crlf;
    record_q.push_back(r);
  endtask

  task automatic end_command();
    bit digits;
    int code, num;
    string w;
    code = 0; num = 0;
    digits = (cmd_len == 3);
    for (int i = 0; i < 3; i++)
      if (cmd_bytes[8*i +: 8] < "0" || cmd_bytes[8*i +: 8] > "9") digits = 0;
    if (digits) begin
      code = 1;
      num = (cmd_bytes[7:0] - 8'h30) * 100 + (cmd_bytes[15:8] - 8'h30) * 10
            + (cmd_bytes[23:16] - 8'h30);
    end else begin
      for (int k = 0; k < 15 && code == 0; k++) begin
        bit same;
        w = cmd_words[k];
        same = (w.len() == cmd_len);
        for (int i = 0; i < w.len() && same; i++)
          if (cmd_bytes[8*i +: 8] != w[i]) same = 0;
        if (same) code = k + 2;
      end
    end
    cmd_kind = code;
    emit(RK_COMMAND, tok_start, span(tok_start, pos), code, num);
  endtask

  task automatic end_param();
    int len;
    bit err, add;
    logic [7:0] mch;
    add = 0; mch = '0;
    if (pcount < 15) pcount++;
    len = span(tok_start, pos);
    err = pcount > param_limit(cmd_kind);
    if (cmd_kind == CODE_MODE && pcount == 2 && !err) begin
      if (len < 2 || (head[7:0] != CH_PLUS && head[7:0] != CH_MINUS)) begin
        err = 1;
      end else begin
        add = head[7:0] == CH_PLUS;
        mch = head[15:8];
      end
    end
    emit(RK_PARAM, tok_start, len, 0, 0, pcount, trailing, err, add, mch);
    head = '0;
  endtask

  task automatic add_cmd_byte(logic [7:0] b);
    if (cmd_len < 7) cmd_bytes[8*cmd_len +: 8] = b;
    if (cmd_len < 8) cmd_len++;
  endtask

  task automatic take(logic [7:0] b);
    int nx, k;
    nx = (pos + 1 > BUF_BYTES) ? BUF_BYTES : pos + 1;
    case (phase)
      P_START: begin
        if (b == CH_COLON) begin
          phase = P_PREFIX; tok_start = nx;
        end else begin
          pfx = PF_NONE; phase = P_COMMAND; tok_start = pos; add_cmd_byte(b);
        end
      end
      P_PREFIX: begin
        if (b == CH_SPACE || b == CH_AT || b == CH_BANG) begin
          if (pfx == PF_UND) begin
            emit(b == CH_SPACE ? RK_SERVER : RK_NICK, tok_start, span(tok_start, pos));
            pfx = (b == CH_SPACE) ? PF_SERVER : PF_USER;
          end else begin
            emit(delim_at ? RK_HOST : RK_USER, tok_start, span(tok_start, pos));
          end
          delim_at = (b == CH_AT);
          tok_start = nx;
          if (b == CH_SPACE) phase = P_COMMAND;
        end
      end
      P_COMMAND: begin
        if (b == CH_SPACE) begin
          end_command();
          phase = param_limit(cmd_kind) != 0 ? P_PARAMS : P_RAW;
          tok_start = nx;
        end else begin
          add_cmd_byte(b);
        end
      end
      P_PARAMS: begin
        if (!trailing && b == CH_COLON && pos == tok_start) begin
          trailing = 1; tok_start = nx;
        end else if (!trailing && b == CH_SPACE) begin
          end_param(); tok_start = nx;
        end else begin
          k = span(tok_start, pos);
          if (pos >= tok_start && k == 0) head[7:0] = b;
          else if (k == 1) head[15:8] = b;
        end
      end
      default: ;
    endcase
    pos = nx;
  endtask

  task automatic finish_message(bit crlf);
    if (phase == P_START) begin
      if (!crlf) begin
        clear_message();
        return;
      end
      phase = P_COMMAND; tok_start = pos;
    end
    if (phase == P_COMMAND) end_command();
    else if (phase == P_PARAMS) end_param();
    else if (phase == P_RAW) emit(RK_RAW, tok_start, span(tok_start, pos));
    emit(RK_END, 0, pos, 0, 0, 0, 0, 0, 0, '0, crlf);
    clear_message();
  endtask

  task automatic predict_item(logic [7:0] b, bit buf_end);
    if (buf_end) begin
      if (cr_held) begin
        cr_held = 0; take(CH_CR);
      end
      finish_message(0);
      return;
    end
    if (cr_held) begin
      cr_held = 0;
      if (b == CH_LF) begin
        finish_message(1);
        return;
      end
      take(CH_CR);
    end
    if (b == CH_CR) cr_held = 1;
    else take(b);
  endtask

  task automatic check_record(rec_t got);
    rec_t want;
    if (record_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("unexpected record: kind %0d data %h", got.kind, got);
      return;
    end
    want = record_q.pop_front();
    if (got !== want) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("record mismatch at %0t", $realtime);
        $display("  kind exp %0d got %0d  off exp %0d got %0d  len exp %0d got %0d",
                 want.kind, got.kind, want.off, got.off, want.len, got.len);
        $display("  code exp %0d got %0d  num exp %0d got %0d  idx exp %0d got %0d",
                 want.code, got.code, want.num, got.num, want.idx, got.idx);
        $display("  trl %0d/%0d err %0d/%0d add %0d/%0d mch %h/%h crlf %0d/%0d",
                 want.trl, got.trl, want.err, got.err, want.add, got.add,
                 want.mch, got.mch, want.crlf, got.crlf);
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    records_seen_o = 0;
    clear_message();
  end

  assign pending_o = record_q.size();

  always @(posedge clk_i) begin
    rec_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = rec_kind_e'(m_axis_tuser);
        got.off  = m_axis_tdata[8:0];
        got.len  = m_axis_tdata[18:9];
        got.code = m_axis_tdata[23:19];
        got.num  = m_axis_tdata[33:24];
        got.idx  = m_axis_tdata[37:34];
        got.trl  = m_axis_tdata[38];
        got.err  = m_axis_tdata[39];
        got.add  = m_axis_tdata[40];
        got.mch  = m_axis_tdata[48:41];
        got.crlf = m_axis_tdata[49];
        records_seen_o++;
        check_record(got);
      end
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata, s_axis_tuser[0]);
    end
  end

  final begin
    if (record_q.size() != 0) fail_count_o += record_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the irc message field parser: stimulus and verdict
module tb_top
  import imfp_pkg::*;
;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int fail_count, pending, records_seen;
  int bytes_sent = 0;
  int messages_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int long_messages = 0;

  string cmd_pick [18] = '{"JOIN", "PART", "PING", "PONG", "NICK", "KICK", "QUIT", "MODE",
    "KILL", "AWAY", "TOPIC", "SQUIT", "ERROR", "NOTICE", "PRIVMSG", "JOINX", "MOD", "privmsg"};

  always #1 clk_i = ~clk_i;

  irc_message_field_parser DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  imfp_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending), .records_seen_o(records_seen)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_item(logic [7:0] b, bit buf_end);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= buf_end;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic string rand_token(int n);
    string s, c;
    s = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0:       c = ":";
        1:       c = "!";
        2:       c = "@";
        3:       c = "\r";
        default: c = string'(8'($urandom_range(8'h61, 8'h7a)));
      endcase
      s = {s, c};
    end
    return s;
  endfunction

  // line with optional random prefix, a command, parameters and optional trailing text
  task automatic send_line();
    string s, cmd;
    int np;
    s = "";
    case ($urandom_range(0, 3))
      0: s = {":", rand_token($urandom_range(0, 5)), " "};
      1: s = {":", rand_token($urandom_range(0, 4)), "!", rand_token($urandom_range(0, 4)),
              "@", rand_token($urandom_range(0, 4)), " "};
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: cmd = $sformatf("%03d", $urandom_range(0, 999));
      1: cmd = rand_token($urandom_range(0, 8));
      default: cmd = cmd_pick[$urandom_range(0, 17)];
    endcase
    s = {s, cmd};
    np = $urandom_range(0, 5);
    for (int i = 0; i < np; i++) begin
      if (cmd == "MODE" && i == 1 && $urandom_range(0, 3) != 0)
        s = {s, " ", ($urandom_range(0, 1) ? "+" : "-"), rand_token($urandom_range(0, 2))};
      else
        s = {s, " ", rand_token($urandom_range(0, 4))};
    end
    if ($urandom_range(0, 1)) s = {s, " :", rand_token($urandom_range(0, 6)), " x:y"};
    send_text(s);
    if ($urandom_range(0, 6) == 0) send_item(8'($urandom()), 1'b1);
    else send_text("\r\n");
    messages_sent++;
  endtask

  // runs past the buffer size so offsets, lengths and parameter index saturate
  task automatic send_long_line();
    send_text("PRIVMSG");
    for (int i = 0; i < 560; i++) send_item(($urandom_range(0, 3) == 0) ? CH_SPACE : 8'h61, 1'b0);
    if ($urandom_range(0, 1)) send_text("\r\n");
    else send_item(8'h00, 1'b1);
    long_messages++;
    messages_sent++;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty line, lone buffer end, full user prefix with numeric, cr before end
    send_text("\r\n");
    send_item(8'hff, 1'b1);
    send_text(":s!u@h 099 \r\n");
    send_text("A\r");
    send_item(8'h00, 1'b1);
    send_text("MODE #c +o x :a:b\r\n");
    send_text(":srv");
    send_item(8'h00, 1'b1);
    messages_sent += 6;

    while (bytes_sent < 1900) begin
      case (bytes_sent * 4 / 1900)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (bytes_sent > 950 && bytes_sent < 1000) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      case ($urandom_range(0, 19))
        0, 1: begin
          repeat ($urandom_range(1, 12)) send_item(8'($urandom()), 1'b0);
          if ($urandom_range(0, 1)) send_item(8'($urandom()), 1'b1);
          messages_sent++;
        end
        2: if (long_messages < 2) send_long_line(); else send_line();
        default: send_line();
      endcase
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d bytes in %0d messages, %0d of them past the buffer size",
             bytes_sent, messages_sent, long_messages);
    $display("checked %0d records under four idle and stall mixes", records_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
